FILE: sv/mmc_pkg.sv
// Package: geometry, config register indexes and shared types for the MAC metadata cache.
package mmc_pkg;
  localparam int NumSets    = 1024;
  localparam int Ways       = 4;
  localparam int LineBytes  = 64;
  localparam int SetBits    = $clog2(NumSets);
  localparam int WayBits    = $clog2(Ways);
  localparam int OffBits    = $clog2(LineBytes);
  localparam int TagBits    = 32 - OffBits - SetBits;
  localparam int AgeBits    = WayBits;
  localparam int LowBits    = 14;
  localparam logic [31:0] MacBase = 32'h0100_0000;

  localparam logic [1:0] RegReplaceMode = 2'd0;
  localparam logic [1:0] RegMacLenLog2  = 2'd1;
  localparam logic [1:0] RegBlockLenLog2 = 2'd2;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [AgeBits-1:0] age;
    logic [TagBits-1:0] tag;
  } line_t;

  typedef line_t [Ways-1:0] set_t;

  typedef struct packed {
    logic         op_store;
    logic [31:0]  mac;
  } req_t;
endpackage

FILE: sv/mmc_set_ram.sv
// Set memory: one row per set holding all ways, registered read.
module mmc_set_ram (
  input  logic                          clk_i,
  input  logic [mmc_pkg::SetBits-1:0]   rd_addr_i,
  output mmc_pkg::set_t                 rd_data_o,
  input  logic                          wr_en_i,
  input  logic [mmc_pkg::SetBits-1:0]   wr_addr_i,
  input  mmc_pkg::set_t                 wr_data_i
);
  import mmc_pkg::*;

  set_t mem [NumSets];
  set_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;
endmodule

FILE: sv/mmc_update.sv
// Lookup and replacement logic: hit detect, victim choice, age, dirty, valid and tag update of one set.
module mmc_update (
  input  mmc_pkg::set_t                 set_i,
  input  logic [mmc_pkg::TagBits-1:0]   tag_i,
  input  logic                          store_i,
  input  logic                          replace_mode_i,
  input  logic [15:0]                   lfsr_next_i,
  output logic                          hit_o,
  output logic                          lfsr_adv_o,
  output logic [mmc_pkg::WayBits-1:0]   way_o,
  output logic                          wb_o,
  output logic [mmc_pkg::TagBits-1:0]   wb_tag_o,
  output mmc_pkg::set_t                 set_o
);
  import mmc_pkg::*;

  logic               found;
  logic [WayBits-1:0] inv_way;
  logic [WayBits-1:0] lru_way;
  logic [AgeBits-1:0] best;
  logic [AgeBits-1:0] hit_age;

  always_comb begin
    hit_o   = 1'b0;
    way_o   = '0;
    found   = 1'b0;
    inv_way = '0;
    lru_way = '0;
    best    = '0;
    hit_age = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (set_i[w].valid && set_i[w].tag == tag_i) begin
        hit_o = 1'b1;
        way_o = WayBits'(w);
      end
      if (!set_i[w].valid) begin
        found   = 1'b1;
        inv_way = WayBits'(w);
      end
    end
    for (int w = 0; w < Ways; w++) begin
      if (set_i[w].age >= best) begin
        best    = set_i[w].age;
        lru_way = WayBits'(w);
      end
    end
    hit_age    = set_i[way_o].age;
    lfsr_adv_o = !hit_o && !found && replace_mode_i;
    if (!hit_o) begin
      if (found) begin
        way_o = inv_way;
      end else if (replace_mode_i) begin
        way_o = lfsr_next_i[15 -: WayBits];
      end else begin
        way_o = lru_way;
      end
    end
    wb_o     = !hit_o && !found && set_i[way_o].dirty;
    wb_tag_o = set_i[way_o].tag;

    set_o = set_i;
    for (int w = 0; w < Ways; w++) begin
      if (hit_o) begin
        if (set_i[w].valid && set_i[w].age < hit_age) begin
          set_o[w].age = set_i[w].age + 1'b1;
        end
      end else if (set_i[w].valid && set_i[w].age != AgeBits'(Ways - 1)) begin
        set_o[w].age = set_i[w].age + 1'b1;
      end
    end
    set_o[way_o].age = '0;
    if (hit_o) begin
      if (store_i) begin
        set_o[way_o].dirty = 1'b1;
      end
    end else begin
      set_o[way_o].valid = 1'b1;
      set_o[way_o].dirty = store_i;
      set_o[way_o].tag   = tag_i;
    end
  end
endmodule

FILE: sv/mac_metadata_cache_lru_top.sv
// Top level: MAC address mapping, set memory read-modify-write and result register.
//
// Usage: raise start with opcode_i and data_address_i while busy is low.
// Each access maps the data address to its MAC address and looks it up in a
// 1024-set, 4-way write-back cache. The set row is read at the accepting
// edge; the next cycle does the lookup and writes the updated row back; the
// cycle after that carries the result beat. busy stays high through the
// lookup and the result beat, so no new access is accepted before that
// beat is over. The result appears for exactly one cycle with done_o high;
// the receiver cannot stall it. Misses raise fill_request_o; a dirty
// victim raises writeback_o with its line address.
// Configuration: cfg_we_i writes register cfg_idx_i (0 replace mode, 1 MAC
// length log2, 2 block length log2); the user must write only while idle,
// as the block itself does not enforce it.
// After reset a clearing pass writes every set row to zero, one row a cycle,
// with busy high; the LFSR resets to 0xACE1 and the registers to their
// defaults.
module mac_metadata_cache_lru_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [31:0] data_address_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  output logic        done_o,
  output logic        hit_o,
  output logic [31:0] mac_address_o,
  output logic [1:0]  way_used_o,
  output logic        fill_request_o,
  output logic        writeback_o,
  output logic [31:0] writeback_address_o
);
  import mmc_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StOut   = 2'd2;
  localparam logic [1:0] StClear = 2'd3;

  logic [1:0]   state_q, state_d;
  logic         mode_q;
  logic [2:0]   mac_log_q;
  logic [3:0]   blk_log_q;
  logic [15:0]  lfsr_q, lfsr_next;
  req_t         req_q;
  logic [31:0]  mac;
  logic [31:0]  low, off, blk;
  logic [3:0]   k;
  set_t         rd_set, wr_set;
  logic         upd_hit, lfsr_adv, upd_wb;
  logic [WayBits-1:0] upd_way;
  logic [TagBits-1:0] wb_tag;
  logic [SetBits-1:0] set_idx;
  logic [SetBits-1:0] clr_q;
  logic         ram_we;
  logic [SetBits-1:0] ram_waddr;
  set_t         ram_wdata;
  logic         hit_q, wb_q;
  logic [1:0]   way_q;
  logic [31:0]  wb_addr_q;

  // Address map: mask the low part, shift the high part, add the MAC base.
  always_comb begin
    low = {18'd0, data_address_i[LowBits-1:0]};
    k   = blk_log_q - {1'b0, mac_log_q};
    off = '0;
    if (blk_log_q > {1'b0, mac_log_q}) begin
      if (k >= 4'(LowBits)) off = low;
      else off = low & ((32'd1 << k) - 32'd1);
    end
    blk = {14'd0, data_address_i[31:LowBits] >> mac_log_q};
    mac = ((blk << LowBits) | off) + MacBase;
  end

  assign set_idx   = req_q.mac[OffBits +: SetBits];
  assign lfsr_next = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  // Clear rows after reset, then write back updated sets.
  assign ram_we    = (state_q == StRead) || (state_q == StClear);
  assign ram_waddr = (state_q == StClear) ? clr_q : set_idx;
  assign ram_wdata = (state_q == StClear) ? set_t'('0) : wr_set;

  mmc_set_ram u_ram (
    .clk_i     (clk_i),
    .rd_addr_i (mac[OffBits +: SetBits]),
    .rd_data_o (rd_set),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata)
  );

  mmc_update u_upd (
    .set_i          (rd_set),
    .tag_i          (req_q.mac[31 -: TagBits]),
    .store_i        (req_q.op_store),
    .replace_mode_i (mode_q),
    .lfsr_next_i    (lfsr_next),
    .hit_o          (upd_hit),
    .lfsr_adv_o     (lfsr_adv),
    .way_o          (upd_way),
    .wb_o           (upd_wb),
    .wb_tag_o       (wb_tag),
    .set_o          (wr_set)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start) state_d = StRead;
      StRead:  state_d = StOut;
      StOut:   state_d = StIdle;
      StClear: if (clr_q == SetBits'(NumSets - 1)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign busy = state_q != StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      mode_q    <= 1'b0;
      mac_log_q <= 3'd3;
      blk_log_q <= 4'd6;
      lfsr_q    <= 16'hACE1;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegReplaceMode:  mode_q    <= cfg_data_i[0];
          RegMacLenLog2:   mac_log_q <= cfg_data_i[2:0];
          RegBlockLenLog2: blk_log_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == StRead && lfsr_adv) lfsr_q <= lfsr_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      req_q.op_store <= opcode_i;
      req_q.mac      <= mac;
    end
    if (state_q == StRead) begin
      hit_q     <= upd_hit;
      way_q     <= 2'(upd_way);
      wb_q      <= upd_wb;
      wb_addr_q <= upd_wb ? {wb_tag, set_idx, {OffBits{1'b0}}} : 32'd0;
    end
  end

  assign done_o              = state_q == StOut;
  assign hit_o               = hit_q;
  assign mac_address_o       = req_q.mac;
  assign way_used_o          = way_q;
  assign fill_request_o      = !hit_q;
  assign writeback_o         = wb_q;
  assign writeback_address_o = wb_addr_q;

  a_done_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRead |=> done_o) else $error("result beat missing");
  a_wb_only_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && writeback_o |-> !hit_o) else $error("writeback on hit");
  a_busy_until_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result while idle");
endmodule
